[design/lns_pkg.sv]
package lns_pkg;

  localparam int unsigned MAX_DIM = 4096;
  localparam int unsigned REG_W   = 13;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned NUM_W   = 24;
  localparam int unsigned DIV_CELLS = COORD_W;

  // configuration register indexes
  localparam logic [1:0] REG_SRC_W = 2'd0;
  localparam logic [1:0] REG_SRC_H = 2'd1;
  localparam logic [1:0] REG_WIN_W = 2'd2;
  localparam logic [1:0] REG_WIN_H = 2'd3;

  // command codes
  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_SHADE = 1'b1;

  // fitted geometry and idle flag; the front takes no new items while it is recomputed
  typedef struct packed {
    logic              idle;
    logic [REG_W-1:0]  sw;
    logic [REG_W-1:0]  sh;
    logic [REG_W-1:0]  fw;
    logic [REG_W-1:0]  fh;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
  } fit_t;

  // item as it travels down the divider row
  typedef struct packed {
    logic               cmd;
    logic               hit;
    logic [NUM_W-1:0]   rx;
    logic [NUM_W-1:0]   ry;
    logic [NUM_W-1:0]   dx;
    logic [NUM_W-1:0]   dy;
    logic [COORD_W-1:0] qx;
    logic [COORD_W-1:0] qy;
    logic [15:0]        pr;
    logic [15:0]        pg;
    logic [15:0]        pb;
  } token_t;

endpackage

[design/lns_in_if.sv]
interface lns_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] win_x;
  logic [11:0] win_y;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;

  modport source(output valid, cmd, win_x, win_y, red, green, blue, alpha, input ready);
  modport sink(input valid, cmd, win_x, win_y, red, green, blue, alpha, output ready);
endinterface

[design/lns_out_if.sv]
interface lns_out_if;
  logic        valid;
  logic        ready;
  logic        inside_res;
  logic [11:0] src_col;
  logic [11:0] src_row;
  logic [23:0] src_addr;
  logic [23:0] pixel;

  modport source(output valid, inside_res, src_col, src_row, src_addr, pixel, input ready);
  modport sink(input valid, inside_res, src_col, src_row, src_addr, pixel, output ready);
endinterface

[design/lns_cfg_if.sv]
interface lns_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [12:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[design/lns_fit.sv]
module lns_fit (
  input  logic                clk,
  input  logic                rst_n,
  lns_cfg_if.sink             cfg_ch,
  output lns_pkg::fit_t       fit
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } fit_state_t;

  fit_state_t state_r, state_nxt;

  logic [12:0] src_w_r, src_h_r, win_w_r, win_h_r;
  logic [12:0] sw, sh, ww, wh;
  logic [25:0] p1, p2;
  logic        wide_r;
  logic [24:0] num_r, dsh_r;
  logic [12:0] q_r;
  logic [3:0]  cnt_r;
  logic [12:0] fw_r, fh_r, fw_sel, fh_sel;
  logic [11:0] px_r, py_r;
  logic        cfg_wr;

  function automatic logic [12:0] eff(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'(lns_pkg::MAX_DIM)) return 13'(lns_pkg::MAX_DIM);
    return v;
  endfunction

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr = cfg_ch.valid;

  assign sw = eff(src_w_r);
  assign sh = eff(src_h_r);
  assign ww = eff(win_w_r);
  assign wh = eff(win_h_r);
  assign p1 = sw * wh;
  assign p2 = sh * ww;

  assign fw_sel = wide_r ? ww : q_r;
  assign fh_sel = wide_r ? q_r : wh;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: state_nxt = ST_IDLE;
      ST_MUL:  state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 4'd0) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (cfg_wr) state_nxt = ST_MUL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      src_w_r <= 13'd1;
      src_h_r <= 13'd1;
      win_w_r <= 13'd1;
      win_h_r <= 13'd1;
      fw_r    <= 13'd1;
      fh_r    <= 13'd1;
      px_r    <= '0;
      py_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (cfg_ch.index)
          lns_pkg::REG_SRC_W: src_w_r <= cfg_ch.data;
          lns_pkg::REG_SRC_H: src_h_r <= cfg_ch.data;
          lns_pkg::REG_WIN_W: win_w_r <= cfg_ch.data;
          lns_pkg::REG_WIN_H: win_h_r <= cfg_ch.data;
          default: ;
        endcase
      end
      if (state_r == ST_DONE && !cfg_wr) begin
        fw_r <= fw_sel;
        fh_r <= fh_sel;
        px_r <= 12'((ww - fw_sel) >> 1);
        py_r <= 12'((wh - fh_sel) >> 1);
      end
    end
  end

  // shift-subtract divider for the fitted short side
  always_ff @(posedge clk) begin
    case (state_r)
      ST_MUL: begin
        wide_r <= (p1 >= p2);
        num_r  <= (p1 >= p2) ? p2[24:0] : p1[24:0];
        dsh_r  <= (p1 >= p2) ? {sw[12:0], 12'd0} : {sh[12:0], 12'd0};
        q_r    <= '0;
        cnt_r  <= 4'd12;
      end
      ST_DIV: begin
        if (num_r >= dsh_r) begin
          num_r <= num_r - dsh_r;
          q_r   <= {q_r[11:0], 1'b1};
        end else begin
          q_r   <= {q_r[11:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - 4'd1;
      end
      default: ;
    endcase
  end

  assign fit.idle = (state_r == ST_IDLE);
  assign fit.sw   = sw;
  assign fit.sh   = sh;
  assign fit.fw   = fw_r;
  assign fit.fh   = fh_r;
  assign fit.px   = px_r;
  assign fit.py   = py_r;

endmodule

[design/lns_front.sv]
module lns_front (
  input  logic                clk,
  input  logic                rst_n,
  lns_in_if.sink              in_ch,
  input  lns_pkg::fit_t       fit,
  input  logic                dn_ready,
  output logic                dn_valid,
  output lns_pkg::token_t     dn_tok
);

  logic            v_r;
  logic            adv;
  lns_pkg::token_t tok_r, tok_nxt;
  logic [12:0]     x13, y13;
  logic            in_x, in_y;
  logic [11:0]     lx, ly;

  assign adv = !v_r || dn_ready;
  assign in_ch.ready = adv && fit.idle;

  assign x13  = {1'b0, in_ch.win_x};
  assign y13  = {1'b0, in_ch.win_y};
  assign in_x = (in_ch.win_x >= fit.px) && (x13 < ({1'b0, fit.px} + fit.fw));
  assign in_y = (in_ch.win_y >= fit.py) && (y13 < ({1'b0, fit.py} + fit.fh));
  assign lx   = in_ch.win_x - fit.px;
  assign ly   = in_ch.win_y - fit.py;

  always_comb begin
    tok_nxt.cmd    = in_ch.cmd;
    tok_nxt.hit    = (in_ch.cmd == lns_pkg::CMD_MAP) && (fit.fw != 13'd0) &&
                     (fit.fh != 13'd0) && in_x && in_y;
    tok_nxt.rx     = 24'(lx * fit.sw);
    tok_nxt.ry     = 24'(ly * fit.sh);
    tok_nxt.dx     = {fit.fw[12:0], 11'd0};
    tok_nxt.dy     = {fit.fh[12:0], 11'd0};
    tok_nxt.qx     = '0;
    tok_nxt.qy     = '0;
    tok_nxt.pr     = in_ch.red * in_ch.alpha;
    tok_nxt.pg     = in_ch.green * in_ch.alpha;
    tok_nxt.pb     = in_ch.blue * in_ch.alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (adv) v_r <= in_ch.valid && fit.idle;
  end

  always_ff @(posedge clk) begin
    if (adv) tok_r <= tok_nxt;
  end

  assign dn_valid = v_r;
  assign dn_tok   = tok_r;

endmodule

[design/lns_div_cell.sv]
module lns_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  lns_pkg::token_t     up_tok,
  output logic                dn_valid,
  input  logic                dn_ready,
  output lns_pkg::token_t     dn_tok
);

  logic            v_r;
  lns_pkg::token_t tok_r, tok_nxt;

  assign up_ready = !v_r || dn_ready;

  // one quotient bit per axis; divisor halves on its way down
  always_comb begin
    tok_nxt = up_tok;
    if (up_tok.rx >= up_tok.dx) begin
      tok_nxt.rx = up_tok.rx - up_tok.dx;
      tok_nxt.qx = {up_tok.qx[10:0], 1'b1};
    end else begin
      tok_nxt.qx = {up_tok.qx[10:0], 1'b0};
    end
    if (up_tok.ry >= up_tok.dy) begin
      tok_nxt.ry = up_tok.ry - up_tok.dy;
      tok_nxt.qy = {up_tok.qy[10:0], 1'b1};
    end else begin
      tok_nxt.qy = {up_tok.qy[10:0], 1'b0};
    end
    tok_nxt.dx = up_tok.dx >> 1;
    tok_nxt.dy = up_tok.dy >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (up_ready) v_r <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (up_ready) tok_r <= tok_nxt;
  end

  assign dn_valid = v_r;
  assign dn_tok   = tok_r;

endmodule

[design/lns_back.sv]
module lns_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  lns_pkg::token_t     up_tok,
  input  lns_pkg::fit_t       fit,
  lns_out_if.source           out_ch
);

  logic        v_r;
  logic        inside_r;
  logic [11:0] col_r, row_r;
  logic [23:0] addr_r, pix_r;
  logic        map_in;

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + 17'(p >> 8) + 17'd1;
    return s[15:8];
  endfunction

  assign up_ready = !v_r || out_ch.ready;
  assign map_in   = (up_tok.cmd == lns_pkg::CMD_MAP) && up_tok.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (up_ready) v_r <= up_valid;
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      inside_r <= map_in;
      col_r    <= map_in ? up_tok.qx : 12'd0;
      row_r    <= map_in ? up_tok.qy : 12'd0;
      addr_r   <= map_in ? 24'(up_tok.qy * fit.sw + {13'd0, up_tok.qx}) : 24'd0;
      pix_r    <= (up_tok.cmd == lns_pkg::CMD_SHADE) ?
                  {div255(up_tok.pr), div255(up_tok.pg), div255(up_tok.pb)} : 24'd0;
    end
  end

  assign out_ch.valid      = v_r;
  assign out_ch.inside_res = inside_r;
  assign out_ch.src_col    = col_r;
  assign out_ch.src_row    = row_r;
  assign out_ch.src_addr   = addr_r;
  assign out_ch.pixel      = pix_r;

endmodule

[design/letterbox_nearest_scaler.sv]
// Stages: front register, 12 divider cells (one quotient bit per axis each), output.
// Throughput: one item per cycle unless stalled by out_ch.ready low or a fit update.
// After a config write the fit unit runs multiply, a 13-step divide and the pad step
// with in_ready low; config transfers are always taken.
// Reset (rst_n, synchronous, active low): registers to 1, fit 1x1 at origin, pipe empty.
module letterbox_nearest_scaler (
  input  logic       clk,
  input  logic       rst_n,
  lns_in_if.sink     in_ch,
  lns_out_if.source  out_ch,
  lns_cfg_if.sink    cfg_ch
);

  // fitted geometry and effective dimensions, recomputed after each config transfer
  lns_pkg::fit_t fit;

  // handshake and token chain through the divider row
  logic            vld [0:lns_pkg::DIV_CELLS];
  logic            rdy [0:lns_pkg::DIV_CELLS];
  lns_pkg::token_t tok [0:lns_pkg::DIV_CELLS];

  lns_fit u_fit (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .fit    (fit)
  );

  // front: offset, inside test, scale products, shade products
  lns_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fit      (fit),
    .dn_ready (rdy[0]),
    .dn_valid (vld[0]),
    .dn_tok   (tok[0])
  );

  // restoring divider, one bit per cell, MSB first
  for (genvar i = 0; i < lns_pkg::DIV_CELLS; i++) begin : g_cell
    lns_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_tok   (tok[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_tok   (tok[i+1])
    );
  end

  // back: linear address, /255 premultiply, output register
  lns_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld[lns_pkg::DIV_CELLS]),
    .up_ready (rdy[lns_pkg::DIV_CELLS]),
    .up_tok   (tok[lns_pkg::DIV_CELLS]),
    .fit      (fit),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // no input transfer while the fit is being recomputed
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> fit.idle) else $error("input taken during fit update");

  // a config transfer blocks input on the next cycle
  a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.ready) |=> !in_ch.ready) else $error("input open after config");

  // map results never carry a pixel
  a_map_nopix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.inside_res) |-> (out_ch.pixel == 24'd0))
    else $error("pixel on map result");

  // mapped column stays within the source width
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.inside_res) |-> ({1'b0, out_ch.src_col} < fit.sw))
    else $error("column out of range");
`endif

endmodule
